// ===== design/tmst_pkg.sv =====
// Shared types, codes and helpers for the tagged mailbox slot table.
// Used by tmst_cell and tagged_mailbox_slot_table_core; depends on nothing.
package tmst_pkg;

  // Default configuration, handed down through the top-level parameters.
  localparam int SLOT_COUNT_DEF   = 8;
  localparam int TASK_ID_BITS_DEF = 8;

  // Fixed field widths on the stream ports.
  localparam int TASK_ID_W  = 8;
  localparam int MSG_DATA_W = 32;
  localparam int MSG_SIZE_W = 3;
  localparam int STATUS_W   = 2;
  localparam int OPCODE_W   = 2;

  // Largest byte count a slot holds.
  localparam logic [MSG_SIZE_W-1:0] MAX_BYTES = 3'd4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SEND  = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2
  } tmst_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } tmst_status_t;

  // Control part of the request token that walks down the row of slots.
  typedef struct packed {
    logic     vld;   // a request occupies this stage
    tmst_op_t op;    // requested operation
    logic     done;  // an earlier slot already took the send or the read
    logic     hit;   // an earlier slot is addressed to the task after update
  } tmst_ctrl_t;

  // Keeps the low n bytes of a word.
  function automatic logic [MSG_DATA_W-1:0] byte_mask(input logic [MSG_SIZE_W-1:0] n);
    logic [MSG_DATA_W-1:0] m;
    unique case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== design/tagged_mailbox_slot_table_core.sv =====
// Top level of the tagged mailbox slot table: a row of tmst_cell slots and
// the result register. Depends on tmst_pkg and tmst_cell.
//
// Usage: each request beat on the in_ stream carries an opcode in in_tuser
// (send, read and remove, or query) and a task id, message word and byte
// count in in_tdata. Every request gives exactly one result beat on the
// out_ stream with a status, the word and byte count of a message read, and
// a flag telling whether any slot is addressed to the task after the request.
//
// The request travels down the row of slots as a token, one slot per cycle while
// the row is not frozen. Each slot sees the token only after the request ahead of
// it has left, so it always sees the state that the earlier request left behind. A send
// claims the first free slot it passes, a read empties the first slot owned
// by its task, and both mark the token done so later slots leave it alone.
// The row is a pipeline, so one request is taken every cycle while no result waits
// with out_tready held low.
//
// When the receiver holds out_tready low while a result waits, the whole row
// and the result register freeze and in_tready drops until the beat is taken.
// Reset frees every slot and empties the row; no result is pending after it.
module tagged_mailbox_slot_table_core import tmst_pkg::*; #(
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // task_id[7:0], msg_data[39:8], msg_size[42:40], zeros
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], out_data[33:2], out_size[36:34],
                                  // has_message[37], zeros
);

  // Token stages; stage 0 is the incoming request, stage SLOT_COUNT leaves
  // the last slot.
  tmst_ctrl_t              ctrl_s  [0:SLOT_COUNT];
  logic [TASK_ID_BITS-1:0] id_s    [0:SLOT_COUNT];
  logic [MSG_DATA_W-1:0]   data_s  [0:SLOT_COUNT];
  logic [MSG_SIZE_W-1:0]   size_s  [0:SLOT_COUNT];
  logic [MSG_DATA_W-1:0]   rdata_s [0:SLOT_COUNT];
  logic [MSG_SIZE_W-1:0]   rsize_s [0:SLOT_COUNT];

  logic                  adv;
  logic [TASK_ID_W-1:0]  in_id;
  logic [MSG_DATA_W-1:0] in_data;
  logic [MSG_SIZE_W-1:0] in_size, sat_size;

  logic                  out_valid_r;
  tmst_status_t          out_status_r, status_nxt;
  logic [MSG_DATA_W-1:0] out_data_r;
  logic [MSG_SIZE_W-1:0] out_size_r;
  logic                  out_has_r;

  // The whole row moves whenever the result register is free or being taken.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign in_id   = in_tdata[TASK_ID_W-1:0];
  assign in_data = in_tdata[TASK_ID_W +: MSG_DATA_W];
  assign in_size = in_tdata[TASK_ID_W+MSG_DATA_W +: MSG_SIZE_W];

  // Counts above four bytes saturate; the word is masked once here so the
  // slots store and return it as is.
  assign sat_size = (in_size > MAX_BYTES) ? MAX_BYTES : in_size;

  always_comb begin
    // Task ids wider than the port are zero above it; narrower ones drop
    // the high bits of the port field.
    for (int b = 0; b < TASK_ID_BITS; b++) begin
      id_s[0][b] = (b < TASK_ID_W) ? in_id[b % TASK_ID_W] : 1'b0;
    end
    ctrl_s[0].vld  = in_tvalid && adv;
    ctrl_s[0].op   = tmst_op_t'(in_tuser);
    ctrl_s[0].done = 1'b0;
    ctrl_s[0].hit  = 1'b0;
    data_s[0]      = in_data & byte_mask(sat_size);
    size_s[0]      = sat_size;
    rdata_s[0]     = '0;
    rsize_s[0]     = '0;
  end

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    tmst_cell #(
      .TASK_ID_BITS(TASK_ID_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctrl_i (ctrl_s[g]),
      .id_i   (id_s[g]),
      .data_i (data_s[g]),
      .size_i (size_s[g]),
      .rdata_i(rdata_s[g]),
      .rsize_i(rsize_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .id_o   (id_s[g+1]),
      .data_o (data_s[g+1]),
      .size_o (size_s[g+1]),
      .rdata_o(rdata_s[g+1]),
      .rsize_o(rsize_s[g+1])
    );
  end

  // A send or read token that reaches the end without being marked done failed: a send
  // found no free slot, or a read found no message. A send to task zero
  // stores nothing and still reports done.
  always_comb begin
    status_nxt = STAT_DONE;
    if (!ctrl_s[SLOT_COUNT].done) begin
      if ((ctrl_s[SLOT_COUNT].op == OP_SEND) && (id_s[SLOT_COUNT] != '0)) begin
        status_nxt = STAT_FULL;
      end else if (ctrl_s[SLOT_COUNT].op == OP_READ) begin
        status_nxt = STAT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctrl_s[SLOT_COUNT].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status_nxt;
      out_data_r   <= rdata_s[SLOT_COUNT];
      out_size_r   <= rsize_s[SLOT_COUNT];
      out_has_r    <= ctrl_s[SLOT_COUNT].hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_has_r, out_size_r, out_data_r, out_status_r};

`ifndef SYNTH
  // A failed request never returns message contents.
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != STAT_DONE) |-> (out_data_r == '0) && (out_size_r == '0))
    else $error("failed request returned message contents");

  // A stalled row keeps its first token in place.
  a_row_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ctrl_s[1]))
    else $error("token moved while the row was stalled");

  // A token leaving the last slot always becomes a result beat.
  a_token_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctrl_s[SLOT_COUNT].vld |=> out_valid_r)
    else $error("token left the row without a result");
`endif

endmodule

// ===== design/tmst_cell.sv =====
// One mailbox slot: owner id, byte count and word, plus one stage of the
// request token that passes through it. Depends on tmst_pkg.
module tmst_cell import tmst_pkg::*; #(
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  tmst_ctrl_t              ctrl_i,
  input  logic [TASK_ID_BITS-1:0] id_i,
  input  logic [MSG_DATA_W-1:0]   data_i,
  input  logic [MSG_SIZE_W-1:0]   size_i,
  input  logic [MSG_DATA_W-1:0]   rdata_i,
  input  logic [MSG_SIZE_W-1:0]   rsize_i,
  output tmst_ctrl_t              ctrl_o,
  output logic [TASK_ID_BITS-1:0] id_o,
  output logic [MSG_DATA_W-1:0]   data_o,
  output logic [MSG_SIZE_W-1:0]   size_o,
  output logic [MSG_DATA_W-1:0]   rdata_o,
  output logic [MSG_SIZE_W-1:0]   rsize_o
);

  logic [TASK_ID_BITS-1:0] owner_r, owner_nxt;
  logic [MSG_DATA_W-1:0]   word_r;
  logic [MSG_SIZE_W-1:0]   bytes_r;

  tmst_ctrl_t              ctrl_r, ctrl_nxt;
  logic [TASK_ID_BITS-1:0] id_r;
  logic [MSG_DATA_W-1:0]   data_r, rdata_r, rdata_nxt;
  logic [MSG_SIZE_W-1:0]   size_r, rsize_r, rsize_nxt;

  logic id_valid, take_send, take_read;

  always_comb begin
    id_valid  = (id_i != '0);
    take_send = ctrl_i.vld && (ctrl_i.op == OP_SEND) && id_valid && !ctrl_i.done
                && (owner_r == '0);
    take_read = ctrl_i.vld && (ctrl_i.op == OP_READ) && id_valid && !ctrl_i.done
                && (owner_r == id_i);

    owner_nxt = owner_r;
    if (take_send) begin
      owner_nxt = id_i;
    end else if (take_read) begin
      owner_nxt = '0;
    end

    ctrl_nxt      = ctrl_i;
    ctrl_nxt.done = ctrl_i.done || take_send || take_read;
    ctrl_nxt.hit  = ctrl_i.hit || (id_valid && (owner_nxt == id_i));

    rdata_nxt = take_read ? word_r  : rdata_i;
    rsize_nxt = take_read ? bytes_r : rsize_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
      ctrl_r  <= '0;
    end else if (adv) begin
      owner_r <= owner_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (take_send) begin
        word_r  <= data_i;
        bytes_r <= size_i;
      end
      id_r    <= id_i;
      data_r  <= data_i;
      size_r  <= size_i;
      rdata_r <= rdata_nxt;
      rsize_r <= rsize_nxt;
    end
  end

  assign ctrl_o  = ctrl_r;
  assign id_o    = id_r;
  assign data_o  = data_r;
  assign size_o  = size_r;
  assign rdata_o = rdata_r;
  assign rsize_o = rsize_r;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for tagged_mailbox_slot_table_core: it streams send, read and
// query requests, predicts every result beat from its own copy of the slot table, and
// compares each beat. Depends on tmst_pkg and the RTL under design/.
`timescale 1ns / 100ps

module tb_top;
  import tmst_pkg::*;

  localparam int SLOT_COUNT   = SLOT_COUNT_DEF;
  localparam int TASK_ID_BITS = TASK_ID_BITS_DEF;
  localparam logic [TASK_ID_W-1:0] ID_MASK = TASK_ID_W'((1 << TASK_ID_BITS) - 1);
  // Opcode 3 has no member in the package enum; the block must treat it as a no-op.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_AT_BEAT = 400;   // result beat after which the receiver holds off
  localparam int HOLD_CYCLES  = 150;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]   op;
    logic [TASK_ID_W-1:0]  id;
    logic [MSG_DATA_W-1:0] data;
    logic [MSG_SIZE_W-1:0] nbytes;
  } mbox_req_t;

  typedef struct packed {
    tmst_status_t          status;
    logic [MSG_DATA_W-1:0] word;
    logic [MSG_SIZE_W-1:0] nbytes;
    logic                  has;
  } mbox_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;    // task_id[7:0], msg_data[39:8], msg_size[42:40], zeros
  logic [1:0]  in_tuser = '0;    // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // status[1:0], out_data[33:2], out_size[36:34],
                                 // has_message[37], zeros

  // Private copy of the slot table, updated as each request beat is accepted.
  logic [MSG_DATA_W-1:0] slot_word  [SLOT_COUNT];
  logic [MSG_SIZE_W-1:0] slot_bytes [SLOT_COUNT];
  logic [TASK_ID_W-1:0]  slot_owner [SLOT_COUNT];

  mbox_req_t    request_q [$];
  mbox_result_t result_q  [$];

  int err_count   = 0;
  int out_beats   = 0;
  int cycle_count = 0;
  int in_gap = 0, in_calm = 0;
  int out_gap = 0, out_calm = 0, hold_left = 0;
  mbox_result_t seen, want;

  tagged_mailbox_slot_table_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [MSG_DATA_W-1:0] low_bytes(input logic [MSG_SIZE_W-1:0] n);
    if (n >= MAX_BYTES) return '1;
    return (32'h1 << (8 * n)) - 32'h1;
  endfunction

  // Lowest slot addressed to id, SLOT_COUNT when none; id zero never matches.
  function automatic int owned_slot(input logic [TASK_ID_W-1:0] id);
    if (id == '0) return SLOT_COUNT;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_owner[i] == id) return i;
    return SLOT_COUNT;
  endfunction

  // Applies one request to the slot table copy and returns the beat it must produce.
  function automatic mbox_result_t mailbox_apply(input mbox_req_t req);
    mbox_result_t r;
    logic [TASK_ID_W-1:0]  id;
    logic [MSG_SIZE_W-1:0] n;
    int slot;
    r = '0;
    r.status = STAT_DONE;
    id = req.id & ID_MASK;
    n = (req.nbytes > MAX_BYTES) ? MAX_BYTES : req.nbytes;
    if (req.op == OP_SEND) begin
      if (id != '0) begin
        slot = SLOT_COUNT;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (slot_owner[i] == '0) slot = i;
        if (slot < SLOT_COUNT) begin
          slot_word[slot]  = req.data & low_bytes(n);
          slot_bytes[slot] = n;
          slot_owner[slot] = id;
        end else begin
          r.status = STAT_FULL;
        end
      end
    end else if (req.op == OP_READ) begin
      slot = owned_slot(id);
      if (slot < SLOT_COUNT) begin
        r.nbytes = slot_bytes[slot];
        r.word   = slot_word[slot] & low_bytes(slot_bytes[slot]);
        slot_word[slot]  = '0;
        slot_bytes[slot] = '0;
        slot_owner[slot] = '0;
      end else begin
        r.status = STAT_NONE;
      end
    end
    r.has = (owned_slot(id) < SLOT_COUNT);
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mbox_req_t make_request(input traffic_mix_t mix);
    mbox_req_t req;
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  req.op = (r < 60) ? OP_SEND : (r < 80) ? OP_READ : (r < 95) ? OP_QUERY
                                                                              : OP_UNUSED;
      MIX_DRAIN: req.op = (r < 20) ? OP_SEND : (r < 75) ? OP_READ : (r < 95) ? OP_QUERY
                                                                              : OP_UNUSED;
      default:   req.op = (r < 40) ? OP_SEND : (r < 75) ? OP_READ : (r < 95) ? OP_QUERY
                                                                              : OP_UNUSED;
    endcase
    // A small pool of tasks keeps reads and queries hitting stored messages.
    r = $urandom_range(0, 99);
    if (r < 80)      req.id = TASK_ID_W'($urandom_range(1, 5));
    else if (r < 95) req.id = TASK_ID_W'($urandom_range(0, 255));
    else             req.id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    r = $urandom_range(0, 99);
    if (r < 5)       req.data = '0;
    else if (r < 10) req.data = '1;
    else             req.data = $urandom;
    req.nbytes = ($urandom_range(0, 99) < 75) ? MSG_SIZE_W'($urandom_range(0, 4))
                                              : MSG_SIZE_W'($urandom_range(5, 7));
    return req;
  endfunction

  task automatic add_request(input logic [OPCODE_W-1:0] op, input logic [TASK_ID_W-1:0] id,
                             input logic [MSG_DATA_W-1:0] data,
                             input logic [MSG_SIZE_W-1:0] nbytes);
    request_q.push_back({op, id, data, nbytes});
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("mismatch on result beat %0d: %s is %0h, expected %0h",
             out_beats, field, got, exp_val);
    err_count++;
  endtask

  // Sender: offers queued requests with random gaps and predicts each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready)
        result_q.push_back(mailbox_apply({in_tuser, in_tdata[7:0], in_tdata[39:8],
                                          in_tdata[42:40]}));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          mbox_req_t req;
          req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= req.op;
          in_tdata  <= {5'b0, req.nbytes, req.data, req.id};
          if (in_calm > 0) begin
            in_calm--;
            in_gap = 0;
          end else begin
            in_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(20, 60);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every taken beat against the oldest prediction and stalls at random.
  // One long hold-off lets the row fill so that in_tready has to drop.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {tmst_status_t'(out_tdata[1:0]), out_tdata[33:2], out_tdata[36:34],
                out_tdata[37]};
        if (result_q.size() == 0) begin
          note_mismatch("unexpected beat, status", 32'(seen.status), 32'h0);
        end else begin
          want = result_q.pop_front();
          if (seen.status !== want.status)
            note_mismatch("status", 32'(seen.status), 32'(want.status));
          if (seen.word !== want.word) note_mismatch("out_data", seen.word, want.word);
          if (seen.nbytes !== want.nbytes)
            note_mismatch("out_size", 32'(seen.nbytes), 32'(want.nbytes));
          if (seen.has !== want.has)
            note_mismatch("has_message", 32'(seen.has), 32'(want.has));
        end
        out_beats++;
        if (out_beats == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_calm > 0) begin
          out_calm--;
          out_gap = 0;
        end else begin
          out_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) out_calm = $urandom_range(20, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    traffic_mix_t mix;
    mix = MIX_EVEN;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_word[i]  = '0;
      slot_bytes[i] = '0;
      slot_owner[i] = '0;
    end

    // Directed part: empty table, every byte count, saturation, full table, task zero,
    // the unused opcode, and a send that refills the lowest freed slot.
    add_request(OP_QUERY,  8'd1,   32'h0,         3'd0);
    add_request(OP_READ,   8'd1,   32'h0,         3'd0);
    add_request(OP_SEND,   8'hFF,  32'hFFFF_FFFF, 3'd4);
    add_request(OP_SEND,   8'd1,   32'h1234_5678, 3'd0);
    add_request(OP_SEND,   8'd2,   32'hA5A5_A5A5, 3'd1);
    add_request(OP_SEND,   8'd3,   32'hFFFF_FFFF, 3'd2);
    add_request(OP_SEND,   8'd4,   32'hDEAD_BEEF, 3'd3);
    add_request(OP_SEND,   8'd5,   32'hCAFE_F00D, 3'd7);
    add_request(OP_SEND,   8'd0,   32'hFFFF_FFFF, 3'd4);
    add_request(OP_SEND,   8'd6,   32'h0000_0000, 3'd5);
    add_request(OP_SEND,   8'd7,   32'h8000_0001, 3'd6);
    add_request(OP_SEND,   8'hAA,  32'h5555_5555, 3'd4);
    add_request(OP_SEND,   8'h55,  32'h7777_7777, 3'd2);
    add_request(OP_SEND,   8'd0,   32'h1111_1111, 3'd1);
    add_request(OP_QUERY,  8'hFF,  32'hFFFF_FFFF, 3'd7);
    add_request(OP_READ,   8'd0,   32'h0,         3'd0);
    add_request(OP_QUERY,  8'd0,   32'h0,         3'd0);
    add_request(OP_UNUSED, 8'd1,   32'hFFFF_FFFF, 3'd7);
    add_request(OP_READ,   8'd1,   32'h0,         3'd0);
    add_request(OP_READ,   8'hFF,  32'h0,         3'd0);
    add_request(OP_READ,   8'd5,   32'h0,         3'd0);
    add_request(OP_READ,   8'd1,   32'h0,         3'd0);
    add_request(OP_SEND,   8'd9,   32'h0F0F_0F0F, 3'd3);
    add_request(OP_READ,   8'd9,   32'hFFFF_FFFF, 3'd7);

    // Random part: the mix swings between filling and draining so that the table
    // regularly reaches both full and empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 48 == 0) mix = traffic_mix_t'($urandom_range(0, 2));
      request_q.push_back(make_request(mix));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() > 0 || in_tvalid) @(posedge clk);
    while (result_q.size() > 0) @(posedge clk);
    repeat (SLOT_COUNT + 20) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tmst_pkg.sv
design/tmst_cell.sv
design/tagged_mailbox_slot_table_core.sv
test/tb_top.sv
